// ===== hdl/eda_pkg.sv =====
// ============================================================================
// eda_pkg
// Shared constants, types and helpers of the Euclidean distance accumulator.
// ============================================================================
`default_nettype none

package eda_pkg;

    localparam int ELEM_W    = 16;
    localparam int ACC_W     = 48;
    localparam int FRAC_BITS = 8;

    localparam int SQ_W    = 2 * ELEM_W;
    localparam int ADD_W   = ((ACC_W > SQ_W) ? ACC_W : SQ_W) + 1;
    localparam int RAD_W   = ACC_W + 2 * FRAC_BITS;
    localparam int ROOT_W  = (RAD_W + 1) / 2;
    localparam int RAD_PAD = 2 * ROOT_W;
    localparam int REM_W   = ROOT_W + 2;
    localparam int CNT_W   = (ROOT_W > 1) ? $clog2(ROOT_W) : 1;
    localparam int DIST_W  = 32;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [ACC_W-1:0] sum;
        logic             clip;
    } t_acc_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } t_root_state;

    function automatic logic [DIST_W-1:0] fit_distance(input logic [ROOT_W-1:0] root);
        logic [ROOT_W:0] lim;
        lim = (ROOT_W + 1)'(33'h0_FFFF_FFFF);
        if ({1'b0, root} > lim) begin
            return '1;
        end
        return DIST_W'(root);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/eda_if.sv =====
// ============================================================================
// eda_if
// Valid/ready channels for element pairs and distance results.
// ============================================================================
`default_nettype none

interface eda_in_if import eda_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ELEM_W-1:0] elem_a;
    logic [ELEM_W-1:0] elem_b;
    logic              last;

    modport source (output valid, output elem_a, output elem_b, output last, input ready);
    modport sink   (input valid, input elem_a, input elem_b, input last, output ready);
endinterface

interface eda_out_if import eda_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance;
    logic              saturated;

    modport source (output valid, output distance, output saturated, input ready);
    modport sink   (input valid, input distance, input saturated, output ready);
endinterface

`default_nettype wire

// ===== hdl/euclidean_distance_accumulator.sv =====
// ============================================================================
// euclidean_distance_accumulator
// Streams element pairs into a sum of squares and returns its scaled root.
// ============================================================================
// throughput: one element pair per cycle while the input is not stalled;
// the root unit takes a new sum once its last root is in the output register
// result path: difference and square registers, queue, root steps, output
// a two-entry queue of finished sums lets the next vector accumulate meanwhile
// pair input stalls only when a last pair meets a full queue
// synchronous active-low reset clears the sum, clip flag, queue and valids
`default_nettype none

module euclidean_distance_accumulator import eda_pkg::*; (
    input  wire       i_clk,
    input  wire       i_rst_n,
    eda_in_if.sink    i_in,
    eda_out_if.source o_out
);

    logic       push;
    logic       pop;
    logic       q_full;
    logic       q_empty;
    t_acc_entry entry;
    t_acc_entry head;

    eda_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_entry  (entry)
    );

    eda_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head)
    );

    eda_root u_root (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_head    (head),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire

// ===== hdl/eda_front.sv =====
// ============================================================================
// eda_front
// Difference, square and saturating accumulation of element pairs.
// ============================================================================
`default_nettype none

module eda_front import eda_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    eda_in_if.sink     i_in,
    input  wire        i_q_full,
    output logic       o_push,
    output t_acc_entry o_entry
);

    logic              r_s1_valid;
    logic              r_s1_last;
    logic [ELEM_W-1:0] r_s1_abs;
    logic              r_s2_valid;
    logic              r_s2_last;
    logic [SQ_W-1:0]   r_s2_sq;
    logic [ACC_W-1:0]  r_sum;
    logic              r_clip;

    logic              stall;
    logic [ELEM_W:0]   diff;
    logic [ELEM_W-1:0] n_abs;
    logic [ADD_W-1:0]  sum_ext;
    logic              ovf;
    logic [ACC_W-1:0]  n_sum;

    assign stall      = r_s2_valid && r_s2_last && i_q_full;
    assign i_in.ready = !stall;

    assign diff  = {i_in.elem_a[ELEM_W-1], i_in.elem_a} - {i_in.elem_b[ELEM_W-1], i_in.elem_b};
    assign n_abs = diff[ELEM_W] ? ELEM_W'(-diff) : diff[ELEM_W-1:0];

    assign sum_ext = ADD_W'(r_sum) + ADD_W'(r_s2_sq);
    assign ovf     = sum_ext > ADD_W'({ACC_W{1'b1}});
    assign n_sum   = ovf ? {ACC_W{1'b1}} : sum_ext[ACC_W-1:0];

    assign o_push        = r_s2_valid && r_s2_last && !i_q_full;
    assign o_entry.sum   = n_sum;
    assign o_entry.clip  = r_clip || ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_sum      <= '0;
            r_clip     <= 1'b0;
        end else if (!stall) begin
            r_s1_valid <= i_in.valid;
            r_s2_valid <= r_s1_valid;
            if (r_s2_valid) begin
                if (r_s2_last) begin
                    r_sum  <= '0;
                    r_clip <= 1'b0;
                end else begin
                    r_sum  <= n_sum;
                    r_clip <= r_clip || ovf;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall) begin
            r_s1_abs  <= n_abs;
            r_s1_last <= i_in.last;
            r_s2_sq   <= SQ_W'(r_s1_abs) * SQ_W'(r_s1_abs);
            r_s2_last <= r_s1_last;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/eda_queue.sv =====
// ============================================================================
// eda_queue
// Short queue of finished sums between accumulation and square root.
// ============================================================================
`default_nettype none

module eda_queue import eda_pkg::*; (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  wire t_acc_entry i_entry,
    input  wire             i_pop,
    output logic            o_full,
    output logic            o_empty,
    output t_acc_entry      o_head
);

    t_acc_entry        r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr_ptr;
    logic [Q_AW-1:0]   r_rd_ptr;
    logic [Q_CW-1:0]   r_count;

    assign o_full  = r_count == Q_CW'(Q_DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CW'(Q_DEPTH))
        else $error("queue count out of range");

endmodule

`default_nettype wire

// ===== hdl/eda_root.sv =====
// ============================================================================
// eda_root
// Bit-serial floor square root of a scaled sum, with output register.
// ============================================================================
`default_nettype none

module eda_root import eda_pkg::*; (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_q_empty,
    input  wire t_acc_entry i_head,
    output logic            o_pop,
    eda_out_if.source       o_out
);

    t_root_state        r_state;
    t_root_state        n_state;
    logic [RAD_PAD-1:0] r_rad;
    logic [REM_W-1:0]   r_rem;
    logic [ROOT_W-1:0]  r_root;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_clip;
    logic               r_out_valid;
    logic [DIST_W-1:0]  r_dist;
    logic               r_sat;

    logic               out_free;
    logic               last_step;
    logic               step;
    logic               load_out;
    logic               load_from_step;
    logic [REM_W-1:0]   rem_sh;
    logic [REM_W-1:0]   trial;
    logic               ge;
    logic [REM_W-1:0]   n_rem;
    logic [ROOT_W-1:0]  n_root;

    assign out_free  = !r_out_valid || o_out.ready;
    assign last_step = r_cnt == '0;

    assign rem_sh = {r_rem[REM_W-3:0], r_rad[RAD_PAD-1 -: 2]};
    assign trial  = {r_root, 2'b01};
    assign ge     = rem_sh >= trial;
    assign n_rem  = ge ? rem_sh - trial : rem_sh;
    assign n_root = {r_root[ROOT_W-2:0], ge};

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (last_step) begin
                    n_state = out_free ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop          = 1'b0;
        step           = 1'b0;
        load_out       = 1'b0;
        load_from_step = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_pop = !i_q_empty;
            end
            ST_RUN: begin
                step           = 1'b1;
                load_out       = last_step && out_free;
                load_from_step = 1'b1;
            end
            ST_HOLD: begin
                load_out = out_free;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rad  <= RAD_PAD'(i_head.sum) << (2 * FRAC_BITS);
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= CNT_W'(ROOT_W - 1);
            r_clip <= i_head.clip;
        end else if (step) begin
            r_rad  <= r_rad << 2;
            r_rem  <= n_rem;
            r_root <= n_root;
            r_cnt  <= r_cnt - 1'b1;
        end
        if (load_out) begin
            r_dist <= fit_distance(load_from_step ? n_root : r_root);
            r_sat  <= r_clip;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.distance  = r_dist;
    assign o_out.saturated = r_sat;

    a_hold_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HOLD) |-> r_out_valid)
        else $error("root held while output register empty");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == ST_RUN && r_cnt == CNT_W'(ROOT_W - 1)))
        else $error("pop did not start a root");

    a_result_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> (r_state == ST_HOLD || (r_state == ST_RUN && last_step)))
        else $error("result loaded outside the final step");

endmodule

`default_nettype wire

// ===== sim/euclidean_distance_accumulator_tb.sv =====
// ============================================================================
// euclidean_distance_accumulator_tb
// Streams element pairs into the accumulator and checks each distance result
// against an in-bench sum-of-squares and integer square root predictor.
// Covers extreme elements, single-pair vectors, a long vector of extreme
// pairs, and random vectors under random stalls on both channels.
// ============================================================================
`default_nettype none

module euclidean_distance_accumulator_tb;
    import eda_pkg::*;

    localparam int          CYCLE_LIMIT = 1_000_000;
    localparam int          IDLE_PCT    = 26;
    localparam int          CALM_FROM   = 3000;
    localparam int          CALM_TO     = 9000;
    localparam int          LONG_PAIRS  = 200;
    localparam int          RANDOM_GOAL = 1330;
    localparam logic [63:0] SUM_CEIL    = (64'd1 << ACC_W) - 64'd1;

    typedef struct {
        logic [ELEM_W-1:0] a;
        logic [ELEM_W-1:0] b;
        logic              last;
        logic              drain;
    } t_pair_item;

    typedef struct {
        logic [DIST_W-1:0] distance;
        logic              saturated;
    } t_dist_result;

    logic i_clk;
    logic i_rst_n;

    eda_in_if  in_if();
    eda_out_if out_if();

    euclidean_distance_accumulator dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    t_pair_item   pair_queue[$];
    t_dist_result dist_due[$];

    logic [63:0] sum_sq;
    logic        sum_clipped;
    int          results_due  = 0;
    int          results_seen = 0;
    int          mismatches   = 0;
    int          cycle_count  = 0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic [31:0] dist_root(input logic [63:0] radicand);
        logic [65:0] rem;
        logic [65:0] trial;
        logic [31:0] root;
        rem  = '0;
        root = '0;
        for (int i = 31; i >= 0; i--) begin
            rem   = (rem << 2) | 66'(radicand[2*i +: 2]);
            trial = 66'({root, 2'b01});
            if (rem >= trial) begin
                rem  = rem - trial;
                root = {root[30:0], 1'b1};
            end else begin
                root = {root[30:0], 1'b0};
            end
        end
        return root;
    endfunction

    task automatic accumulate_pair(input logic [ELEM_W-1:0] a, input logic [ELEM_W-1:0] b,
                                   input logic last);
        logic signed [ELEM_W:0] diff;
        logic [ELEM_W:0]        mag;
        logic [63:0]            sq;
        t_dist_result           res;
        diff = $signed({a[ELEM_W-1], a}) - $signed({b[ELEM_W-1], b});
        mag  = diff[ELEM_W] ? -diff : diff;
        sq   = 64'(mag) * 64'(mag);
        if (sq > SUM_CEIL - sum_sq) begin
            sum_sq      = SUM_CEIL;
            sum_clipped = 1'b1;
        end else begin
            sum_sq = sum_sq + sq;
        end
        if (last) begin
            res.distance  = dist_root(sum_sq << (2 * FRAC_BITS));
            res.saturated = sum_clipped;
            dist_due.push_back(res);
            results_due++;
            sum_sq      = '0;
            sum_clipped = 1'b0;
        end
    endtask

    task automatic add_pair(input logic [ELEM_W-1:0] a, input logic [ELEM_W-1:0] b,
                            input logic last, input logic drain);
        t_pair_item item;
        item.a     = a;
        item.b     = b;
        item.last  = last;
        item.drain = drain;
        pair_queue.push_back(item);
    endtask

    function automatic logic [ELEM_W-1:0] pick_elem(input logic [ELEM_W-1:0] near);
        int kind;
        kind = $urandom_range(9);
        case (kind)
            0, 1, 2, 3, 4: return ELEM_W'($urandom);
            5, 6: return ELEM_W'($urandom_range(16) - 8);
            7: begin
                case ($urandom_range(3))
                    0: return {1'b0, {(ELEM_W-1){1'b1}}};
                    1: return {1'b1, {(ELEM_W-1){1'b0}}};
                    2: return '1;
                    default: return '0;
                endcase
            end
            default: return near + ELEM_W'($urandom_range(64) - 32);
        endcase
    endfunction

    function automatic logic side_idle();
        if (cycle_count >= CALM_FROM && cycle_count < CALM_TO) begin
            return 1'b0;
        end
        return ($urandom_range(99) < IDLE_PCT);
    endfunction

    // pair driver
    always @(posedge i_clk) begin
        logic go;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            sum_sq      = '0;
            sum_clipped = 1'b0;
        end else if (!in_if.valid || in_if.ready) begin
            if (in_if.valid) begin
                accumulate_pair(in_if.elem_a, in_if.elem_b, in_if.last);
                void'(pair_queue.pop_front());
            end
            go = (pair_queue.size() != 0) && !side_idle();
            if (go && pair_queue[0].drain && results_due != results_seen) begin
                go = 1'b0;
            end
            in_if.valid <= go;
            if (go) begin
                in_if.elem_a <= pair_queue[0].a;
                in_if.elem_b <= pair_queue[0].b;
                in_if.last   <= pair_queue[0].last;
            end
        end
    end

    // distance monitor
    always @(posedge i_clk) begin
        t_dist_result want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (dist_due.size() == 0) begin
                    $error("unexpected result: distance %0d saturated %0b",
                           out_if.distance, out_if.saturated);
                    mismatches++;
                end else begin
                    want = dist_due.pop_front();
                    if (out_if.distance !== want.distance) begin
                        $error("distance: expected %0d, got %0d", want.distance,
                               out_if.distance);
                        mismatches++;
                    end
                    if (out_if.saturated !== want.saturated) begin
                        $error("saturated: expected %0b, got %0b", want.saturated,
                               out_if.saturated);
                        mismatches++;
                    end
                end
                results_seen <= results_seen + 1;
            end
            out_if.ready <= !side_idle();
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int                random_items;
        int                vec_len;
        logic [ELEM_W-1:0] a;
        logic [ELEM_W-1:0] b;

        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.elem_a = '0;
        in_if.elem_b = '0;
        in_if.last   = 1'b0;
        out_if.ready = 1'b0;

        // single-pair vectors at the extremes
        add_pair(16'sd0, 16'sd0, 1'b1, 1'b0);
        add_pair(16'sh7FFF, 16'sh8000, 1'b1, 1'b0);
        add_pair(16'sh8000, 16'sh7FFF, 1'b1, 1'b0);
        add_pair(16'sd1, 16'sd0, 1'b1, 1'b0);
        add_pair(16'shFFFF, 16'sh0001, 1'b1, 1'b0);
        // short multi-pair vectors
        add_pair(16'shFFFF, 16'shFFFF, 1'b0, 1'b0);
        add_pair(16'sd3, 16'sd0, 1'b0, 1'b0);
        add_pair(16'sd0, 16'sd4, 1'b1, 1'b0);
        add_pair(16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0);
        add_pair(16'sh8000, 16'sh8000, 1'b1, 1'b0);
        add_pair(16'sh5555, 16'shAAAA, 1'b0, 1'b0);
        add_pair(16'shAAAA, 16'sh5555, 1'b0, 1'b0);
        add_pair(16'sd7, 16'sd7, 1'b1, 1'b0);
        add_pair(16'sd12345, -16'sd54, 1'b0, 1'b0);
        add_pair(-16'sd100, 16'sd200, 1'b0, 1'b0);
        add_pair(16'sh00FF, 16'shFF00, 1'b1, 1'b0);

        // long vector of extreme pairs, then a clean vector
        for (int i = 0; i < LONG_PAIRS; i++) begin
            add_pair(16'sh7FFF, 16'sh8000, (i == LONG_PAIRS - 1), (i == 0));
        end
        add_pair(16'sd2, -16'sd2, 1'b1, 1'b0);

        random_items = 0;
        a = '0;
        b = '0;
        while (random_items < RANDOM_GOAL) begin
            vec_len = ($urandom_range(99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 40);
            for (int i = 0; i < vec_len; i++) begin
                a = pick_elem(b);
                b = pick_elem(a);
                add_pair(a, b, (i == vec_len - 1), (i == 0) && ($urandom_range(99) < 2));
                random_items++;
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pair_queue.size() != 0 || in_if.valid) begin
            @(posedge i_clk);
        end
        while (results_due != results_seen) begin
            @(posedge i_clk);
        end
        repeat (80) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
